### rtl/fsg_pkg.sv
// shared constants, action codes and control types for the falling sand grid
package fsg_pkg;

    // grid geometry
    localparam int GRID_WIDTH  = 640;
    localparam int GRID_HEIGHT = 480;

    localparam int COL_W  = $clog2(GRID_WIDTH);
    localparam int ROW_W  = (GRID_HEIGHT > 2) ? $clog2(GRID_HEIGHT) : 1;

    // input word field widths
    localparam int ACTION_W = 2;
    localparam int COL_IN_W = 10;
    localparam int ROW_IN_W = 9;

    // action codes
    localparam logic [ACTION_W-1:0] ACT_PLACE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // row engine control from the sequencer
    typedef struct packed {
        logic ld_below_mem;
        logic ld_below_here;
        logic ld_here;
        logic step;
    } eng_ctl_t;

    // row engine status back to the sequencer
    typedef struct packed {
        logic last_col;
    } eng_sts_t;

endpackage

### rtl/falling_sand_grid_step.sv
// top level: falling sand grid with row memory, sequencer and output register
//
//   channel | handshake          | words
//   --------+--------------------+-------------------------------
//   in      | in_valid, in_stall | action, col, row
//   out     | out_valid,out_stall| occupied, done_res
//
// place reads its row and writes it back with the cell set, read reads its row
// and takes the cell bit, out of range or unused codes go straight to the response
// tick is run by the row engine sweeping one cell per cycle over each row pair
// after reset a clearing pass writes GRID_HEIGHT rows, one row a cycle,
// with in_stall high; one action runs at a time, and a result that waits
// on out_stall blocks the next result but not the next accept
module falling_sand_grid_step
    import fsg_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [ACTION_W-1:0] action,
    input  logic [COL_IN_W-1:0] col,
    input  logic [ROW_IN_W-1:0] row,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                occupied,
    output logic                done_res
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_PRD    = 4'd2;
    localparam logic [3:0] ST_PWR    = 4'd3;
    localparam logic [3:0] ST_RRD    = 4'd4;
    localparam logic [3:0] ST_RDAT   = 4'd5;
    localparam logic [3:0] ST_TSTART = 4'd6;
    localparam logic [3:0] ST_TLDB   = 4'd7;
    localparam logic [3:0] ST_TLDH   = 4'd8;
    localparam logic [3:0] ST_TRUN   = 4'd9;
    localparam logic [3:0] ST_TWB    = 4'd10;
    localparam logic [3:0] ST_TWB0   = 4'd11;
    localparam logic [3:0] ST_RESP   = 4'd12;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [ROW_W-1:0] TOP_PASS = ROW_W'(GRID_HEIGHT - 2);

    logic [3:0]          state_reg, state_next;
    logic [ROW_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]    pass_row_reg, pass_row_next;
    logic [COL_W-1:0]    cell_col_reg, cell_col_next;
    logic [ROW_W-1:0]    cell_row_reg, cell_row_next;
    logic                resp_occ_reg, resp_occ_next;
    logic                resp_done_reg, resp_done_next;
    logic                out_valid_reg, out_valid_next;
    logic                occupied_reg, occupied_next;
    logic                done_res_reg, done_res_next;

    logic                  accept;
    logic                  in_range;
    logic                  ram_wr_en, ram_rd_en;
    logic [ROW_W-1:0]      ram_wr_addr, ram_rd_addr;
    logic [GRID_WIDTH-1:0] ram_wr_data, ram_rd_data;
    logic [GRID_WIDTH-1:0] set_mask;
    logic [GRID_WIDTH-1:0] here_row, below_row;
    eng_ctl_t              eng_ctl;
    eng_sts_t              eng_sts;

    fsg_ram #(
        .WIDTH (GRID_WIDTH),
        .DEPTH (GRID_HEIGHT)
    ) u_grid_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    fsg_row_engine u_row_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (eng_ctl),
        .rd_data   (ram_rd_data),
        .here_row  (here_row),
        .below_row (below_row),
        .sts       (eng_sts)
    );

    // input handshake
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = (int'(col) < GRID_WIDTH) && (int'(row) < GRID_HEIGHT);
    assign set_mask = {{(GRID_WIDTH-1){1'b0}}, 1'b1} << cell_col_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        pass_row_next  = pass_row_reg;
        cell_col_next  = cell_col_reg;
        cell_row_next  = cell_row_reg;
        resp_occ_next  = resp_occ_reg;
        resp_done_next = resp_done_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = '0;
        ram_wr_data    = '0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = '0;
        eng_ctl        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == LAST_ROW)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    cell_col_next  = COL_W'(col);
                    cell_row_next  = ROW_W'(row);
                    resp_occ_next  = 1'b0;
                    resp_done_next = 1'b1;
                    priority if (action == ACT_TICK)
                    begin
                        state_next = ST_TSTART;
                    end
                    else if (action == ACT_PLACE && in_range)
                    begin
                        state_next = ST_PRD;
                    end
                    else if (action == ACT_READ && in_range)
                    begin
                        state_next = ST_RRD;
                    end
                    else if (action == ACT_PLACE || action == ACT_READ)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        resp_done_next = 1'b0;
                        state_next     = ST_RESP;
                    end
                end
            end
            ST_PRD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cell_row_reg;
                state_next  = ST_PWR;
            end
            ST_PWR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cell_row_reg;
                ram_wr_data = ram_rd_data | set_mask;
                state_next  = ST_RESP;
            end
            ST_RRD:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = cell_row_reg;
                state_next  = ST_RDAT;
            end
            ST_RDAT:
            begin
                resp_occ_next = ram_rd_data[cell_col_reg];
                state_next    = ST_RESP;
            end
            ST_TSTART:
            begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = LAST_ROW;
                state_next  = ST_TLDB;
            end
            ST_TLDB:
            begin
                eng_ctl.ld_below_mem = 1'b1;
                ram_rd_en            = 1'b1;
                ram_rd_addr          = TOP_PASS;
                pass_row_next        = TOP_PASS;
                state_next           = ST_TLDH;
            end
            ST_TLDH:
            begin
                eng_ctl.ld_here = 1'b1;
                if (pass_row_reg != '0)
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pass_row_reg - 1'b1;
                end
                state_next = ST_TRUN;
            end
            ST_TRUN:
            begin
                eng_ctl.step = 1'b1;
                if (eng_sts.last_col)
                begin
                    state_next = ST_TWB;
                end
            end
            ST_TWB:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pass_row_reg + 1'b1;
                ram_wr_data = below_row;
                if (pass_row_reg == '0)
                begin
                    state_next = ST_TWB0;
                end
                else
                begin
                    // finished row becomes the row below, prefetched row moves in
                    eng_ctl.ld_below_here = 1'b1;
                    eng_ctl.ld_here       = 1'b1;
                    pass_row_next         = pass_row_reg - 1'b1;
                    if (pass_row_reg > ROW_W'(1))
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pass_row_reg - ROW_W'(2);
                    end
                    state_next = ST_TRUN;
                end
            end
            ST_TWB0:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = '0;
                ram_wr_data = here_row;
                state_next  = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        occupied_next  = occupied_reg;
        done_res_next  = done_res_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (state_reg == ST_RESP && (!out_valid_reg || !out_stall))
        begin
            out_valid_next = 1'b1;
            occupied_next  = resp_occ_reg;
            done_res_next  = resp_done_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pass_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pass_row_reg  <= pass_row_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cell_col_reg  <= cell_col_next;
        cell_row_reg  <= cell_row_next;
        resp_occ_reg  <= resp_occ_next;
        resp_done_reg <= resp_done_next;
        occupied_reg  <= occupied_next;
        done_res_reg  <= done_res_next;
    end

    assign out_valid = out_valid_reg;
    assign occupied  = occupied_reg;
    assign done_res  = done_res_reg;

`ifndef SYNTHESIS
    // no read and write of the same row in one cycle
    a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_wr_en && ram_rd_en && (ram_wr_addr == ram_rd_addr)))
        else $error("row read and written in the same cycle");

    // a new result word appears only out of the response state
    a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_RESP))
        else $error("result word without a finished action");

    // an accepted tick starts the pass at once
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && action == ACT_TICK) |=> (state_reg == ST_TSTART))
        else $error("tick accepted but pass not started");

    // the row sweep leaves only at the last column
    a_sweep_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRUN && !eng_sts.last_col) |=> (state_reg == ST_TRUN))
        else $error("row sweep ended before the last column");
`endif

endmodule

### rtl/fsg_ram.sv
// generic single-write, single-read synchronous ram with registered read data
module fsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/fsg_row_engine.sv
// row engine: sweeps one row over the row below, one cell per cycle while step is high
module fsg_row_engine
    import fsg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  eng_ctl_t              ctl,
    input  logic [GRID_WIDTH-1:0] rd_data,
    output logic [GRID_WIDTH-1:0] here_row,
    output logic [GRID_WIDTH-1:0] below_row,
    output eng_sts_t              sts
);

    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_WIDTH - 1);

    // here row rotates so bit 0 is the current column;
    // below row rotates so bits 0..2 are columns c-1, c, c+1
    logic [GRID_WIDTH-1:0] here_sr_reg, here_sr_next;
    logic [GRID_WIDTH-1:0] below_sr_reg, below_sr_next;
    logic [COL_W-1:0]      col_cnt_reg, col_cnt_next;

    logic                  grain, bl, bc, br;
    logic                  first_col, last_col;
    logic                  mv_down, mv_left, mv_right, keep;
    logic [GRID_WIDTH-1:0] below_mod;

    // decide the move of the current grain
    always_comb
    begin
        grain     = here_sr_reg[0];
        bl        = below_sr_reg[0];
        bc        = below_sr_reg[1];
        br        = below_sr_reg[2];
        first_col = (col_cnt_reg == '0);
        last_col  = (col_cnt_reg == LAST_COL);
        mv_down   = grain && !bc;
        mv_left   = grain && bc && !first_col && !bl;
        mv_right  = grain && bc && (first_col || bl) && !last_col && !br;
        keep      = grain && !(mv_down || mv_left || mv_right);
        below_mod = below_sr_reg;
        if (mv_left)
        begin
            below_mod[0] = 1'b1;
        end
        if (mv_down)
        begin
            below_mod[1] = 1'b1;
        end
        if (mv_right)
        begin
            below_mod[2] = 1'b1;
        end
    end

    // shift line updates
    always_comb
    begin
        here_sr_next  = here_sr_reg;
        below_sr_next = below_sr_reg;
        col_cnt_next  = col_cnt_reg;
        priority if (ctl.ld_below_here)
        begin
            below_sr_next = {here_sr_reg[GRID_WIDTH-2:0], here_sr_reg[GRID_WIDTH-1]};
        end
        else if (ctl.ld_below_mem)
        begin
            below_sr_next = {rd_data[GRID_WIDTH-2:0], rd_data[GRID_WIDTH-1]};
        end
        else if (ctl.step)
        begin
            below_sr_next = {below_mod[0], below_mod[GRID_WIDTH-1:1]};
        end
        priority if (ctl.ld_here)
        begin
            here_sr_next = rd_data;
            col_cnt_next = '0;
        end
        else if (ctl.step)
        begin
            here_sr_next = {keep, here_sr_reg[GRID_WIDTH-1:1]};
            if (!last_col)
            begin
                col_cnt_next = col_cnt_reg + 1'b1;
            end
        end
    end

    // column counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
        end
    end

    // row buffers
    always_ff @(posedge clk)
    begin
        here_sr_reg  <= here_sr_next;
        below_sr_reg <= below_sr_next;
    end

    // rows back in column order once a sweep is complete
    assign here_row     = here_sr_reg;
    assign below_row    = {below_sr_reg[0], below_sr_reg[GRID_WIDTH-1:1]};
    assign sts.last_col = last_col;

endmodule

### verif/tb_top.sv
// testbench for the falling sand grid: directed and random words checked against a grid predictor
`timescale 1ns / 1ps

module tb_top;
    import fsg_pkg::*;

    localparam int    CLK_HALF      = 6;
    localparam int    CLK_PERIOD    = 2 * CLK_HALF;
    localparam int    RESET_CYCLES  = 4;
    localparam int    RANDOM_WORDS  = 75;
    localparam int    DIRECTED_MAX  = 25;
    localparam int    MAX_GAP       = 8;
    localparam int    MAX_BURST     = 12;
    localparam int    MAX_STALL_RUN = 8;
    localparam int    DRAIN_CYCLES  = 20;
    localparam int    REPORT_LIMIT  = 10;
    localparam int    TICK_COUNT    = 3;

    // the one action code the package leaves unnamed
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    // slowest correct run: clearing pass, every tick, every word with its worst gap and stall
    localparam longint TICK_CYCLES = longint'(GRID_HEIGHT - 1) * (GRID_WIDTH + 1) + 6;
    localparam longint WORD_CYCLES = MAX_GAP + 8 * MAX_STALL_RUN + 4;
    localparam longint SLOWEST_CYCLES = GRID_HEIGHT + TICK_COUNT * TICK_CYCLES
                                      + (DIRECTED_MAX + RANDOM_WORDS) * WORD_CYCLES;
    localparam longint LIMIT_NS = 4 * SLOWEST_CYCLES * CLK_PERIOD;

    typedef struct packed {
        logic occupied;
        logic done_res;
    } sand_result_t;

    // grid predictor and queue of expected result words
    class sand_grid_board;
        bit           cells [GRID_HEIGHT][GRID_WIDTH];
        sand_result_t expected_q[$];
        int           failures;

        // a column past either side edge reads as full
        function bit is_full(int r, int c);
            if (c < 0 || c >= GRID_WIDTH)
                return 1'b1;
            return cells[r][c];
        endfunction

        // one in-place pass, bottom-but-one row upward, left to right
        function void settle_pass();
            int r;
            int c;
            for (r = GRID_HEIGHT - 2; r >= 0; r--)
            begin
                for (c = 0; c < GRID_WIDTH; c++)
                begin
                    if (cells[r][c])
                    begin
                        if (!is_full(r + 1, c))
                        begin
                            cells[r + 1][c] = 1'b1;
                            cells[r][c]     = 1'b0;
                        end
                        else if (!is_full(r + 1, c - 1))
                        begin
                            cells[r + 1][c - 1] = 1'b1;
                            cells[r][c]         = 1'b0;
                        end
                        else if (!is_full(r + 1, c + 1))
                        begin
                            cells[r + 1][c + 1] = 1'b1;
                            cells[r][c]         = 1'b0;
                        end
                    end
                end
            end
        endfunction

        // apply an accepted input word and queue the result it causes
        function void note_word(logic [ACTION_W-1:0] act, logic [COL_IN_W-1:0] c,
                                logic [ROW_IN_W-1:0] r);
            sand_result_t res;
            logic         in_grid;
            in_grid      = (c < GRID_WIDTH) && (r < GRID_HEIGHT);
            res.occupied = 1'b0;
            res.done_res = 1'b1;
            case (act)
                ACT_PLACE:
                begin
                    if (in_grid)
                        cells[r][c] = 1'b1;
                end
                ACT_TICK:
                    settle_pass();
                ACT_READ:
                begin
                    if (in_grid)
                        res.occupied = cells[r][c];
                end
                default:
                    res.done_res = 1'b0;
            endcase
            expected_q.push_back(res);
        endfunction

        // compare an accepted result word with the oldest expectation
        function void check_word(logic occ, logic done);
            sand_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("unexpected result word: occupied=%0b done_res=%0b", occ, done);
                return;
            end
            exp_res = expected_q.pop_front();
            if (occ !== exp_res.occupied || done !== exp_res.done_res)
            begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("mismatch: occupied exp=%0b act=%0b, done_res exp=%0b act=%0b",
                             exp_res.occupied, occ, exp_res.done_res, done);
            end
        endfunction
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_stall;
    logic [ACTION_W-1:0] action    = ACT_PLACE;
    logic [COL_IN_W-1:0] col       = '0;
    logic [ROW_IN_W-1:0] row       = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                occupied;
    logic                done_res;

    sand_grid_board board = new();

    int burst_left      = 0;
    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run_left  = 0;

    falling_sand_grid_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .col       (col),
        .row       (row),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .occupied  (occupied),
        .done_res  (done_res)
    );

    // clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // receiver stall pattern: modes of none, light and heavy stalling
    always @(negedge clk)
    begin
        if (stall_mode_left == 0)
        begin
            stall_mode      = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(16, 64);
        end
        stall_mode_left--;
        if (stall_run_left == 0)
        begin
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= 1'($urandom_range(0, 1));
            endcase
            stall_run_left = $urandom_range(1, MAX_STALL_RUN);
        end
        stall_run_left--;
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_word(occupied, done_res);
    end

    // send one input word, with bursts and gaps on the sender side
    task automatic send_word(input logic [ACTION_W-1:0] act, input logic [COL_IN_W-1:0] c,
                             input logic [ROW_IN_W-1:0] r);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, MAX_GAP);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            burst_left = $urandom_range(1, MAX_BURST);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        action   <= act;
        col      <= c;
        row      <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        board.note_word(act, c, r);
    endtask

    // columns near both side edges and the middle, sometimes anywhere
    function automatic logic [COL_IN_W-1:0] hot_col();
        case ($urandom_range(0, 3))
            0:       return COL_IN_W'($urandom_range(0, 5));
            1:       return COL_IN_W'($urandom_range(GRID_WIDTH - 6, GRID_WIDTH - 1));
            2:       return COL_IN_W'($urandom_range(GRID_WIDTH / 2 - 4, GRID_WIDTH / 2 + 4));
            default: return COL_IN_W'($urandom_range(0, GRID_WIDTH - 1));
        endcase
    endfunction

    // rows mostly near the bottom, where grains pile up within a few passes
    function automatic logic [ROW_IN_W-1:0] hot_row();
        if ($urandom_range(0, 9) != 0)
            return ROW_IN_W'($urandom_range(GRID_HEIGHT - 8, GRID_HEIGHT - 1));
        return ROW_IN_W'($urandom_range(0, GRID_HEIGHT - 1));
    endfunction

    // stimulus
    initial
    begin
        int                  i;
        int                  pick;
        logic [COL_IN_W-1:0] rc;
        logic [ROW_IN_W-1:0] rr;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // corners, out of range fields, all-ones fields, unused code
        send_word(ACT_READ,  0, 0);
        send_word(ACT_PLACE, 0, 0);
        send_word(ACT_READ,  0, 0);
        send_word(ACT_PLACE, COL_IN_W'(GRID_WIDTH - 1), ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_READ,  COL_IN_W'(GRID_WIDTH - 1), ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_PLACE, COL_IN_W'(GRID_WIDTH), 0);
        send_word(ACT_PLACE, 10'h3FF, 9'h1FF);
        send_word(ACT_READ,  10'h3FF, 9'h1FF);
        send_word(ACT_PLACE, 5, ROW_IN_W'(GRID_HEIGHT));
        send_word(ACT_READ,  5, ROW_IN_W'(GRID_HEIGHT));
        send_word(ACT_UNUSED, 10'h3FF, 9'h1FF);

        // edge slides, blocked fall, chain fall in one pass
        send_word(ACT_PLACE, 0, ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_PLACE, 0, ROW_IN_W'(GRID_HEIGHT - 2));
        send_word(ACT_PLACE, COL_IN_W'(GRID_WIDTH - 1), ROW_IN_W'(GRID_HEIGHT - 2));
        send_word(ACT_PLACE, 320, ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_PLACE, 320, ROW_IN_W'(GRID_HEIGHT - 2));
        send_word(ACT_PLACE, 319, ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_PLACE, 100, ROW_IN_W'(GRID_HEIGHT - 3));
        send_word(ACT_PLACE, 200, ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_PLACE, 200, ROW_IN_W'(GRID_HEIGHT - 2));
        send_word(ACT_PLACE, 200, ROW_IN_W'(GRID_HEIGHT - 3));
        send_word(ACT_TICK,  0, 0);
        send_word(ACT_READ,  1, ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_READ,  COL_IN_W'(GRID_WIDTH - 2), ROW_IN_W'(GRID_HEIGHT - 1));
        send_word(ACT_READ,  200, ROW_IN_W'(GRID_HEIGHT - 2));

        // random words: mostly places and reads around piles, two more passes
        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            if (i == RANDOM_WORDS / 3 || i == 2 * RANDOM_WORDS / 3)
            begin
                send_word(ACT_TICK, COL_IN_W'($urandom_range(0, 1023)),
                          ROW_IN_W'($urandom_range(0, 511)));
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    send_word(ACT_PLACE, hot_col(), hot_row());
                end
                else if (pick < 85)
                begin
                    send_word(ACT_READ, hot_col(), hot_row());
                end
                else if (pick < 93)
                begin
                    if ($urandom_range(0, 1))
                    begin
                        rc = COL_IN_W'($urandom_range(GRID_WIDTH, 1023));
                        rr = ROW_IN_W'($urandom_range(0, 511));
                    end
                    else
                    begin
                        rc = COL_IN_W'($urandom_range(0, 1023));
                        rr = ROW_IN_W'($urandom_range(GRID_HEIGHT, 511));
                    end
                    send_word($urandom_range(0, 1) ? ACT_PLACE : ACT_READ, rc, rr);
                end
                else
                begin
                    send_word(ACT_UNUSED, COL_IN_W'($urandom_range(0, 1023)),
                              ROW_IN_W'($urandom_range(0, 511)));
                end
            end
        end

        @(negedge clk);
        in_valid <= 1'b0;

        // drain
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.failures == 0 && board.expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // run limit
    initial
    begin
        #(LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
